// File: design/fpp_pkg.sv
// Shared types, constants and the CRC byte update for the framed packet parser.
package fpp_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_CRC_ERR  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  // One result item as held in the output register
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pkt_type;
    logic [7:0]  frame_flags;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        last;
  } result_t;

  // MSB-first CRC update over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/fpp_if.sv
// Valid/ready channel interfaces for the received bytes and the parser results.
interface fpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_out_if
  import fpp_pkg::*;
  ;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  pkt_type;
  logic [7:0]  frame_flags;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  logic        last;

  modport source (
    output valid, output kind, output pkt_type, output frame_flags, output payload_length,
    output data_byte, output received_crc, output computed_crc, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input pkt_type, input frame_flags, input payload_length,
    input data_byte, input received_crc, input computed_crc, input last,
    output ready
  );
endinterface

// File: design/fpp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module fpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/framed_packet_parser_crc16.sv
// Top level: sync-framed packet parser with CRC-16/CCITT-FALSE and payload buffer.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------------------
//   in_if   | in  | valid/ready         | rx_byte
//   out_if  | out | valid/ready         | kind, pkt_type, frame_flags, payload_length,
//           |     |                     | data_byte, received_crc, computed_crc, last
//   cfg     | in  | cfg_we_i, no stall  | cfg_idx_i, cfg_data_i (sync_first, sync_second)
//
// One received byte is taken per cycle unless input is held off; header and payload
// bytes advance the CRC. A good frame of N payload bytes gives its header with the
// CRC high byte, which also issues the first RAM read, then N payload results one
// per cycle unless out_if stalls, read from the payload RAM with input held off.
// Reset clears all control state at once; the payload RAM needs no clearing.
// A result waiting on out_if stalls input only on bytes that can make a result.
module framed_packet_parser_crc16
  import fpp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  fpp_in_if.sink             in_if,
  fpp_out_if.source          out_if
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_TYPE  = 4'd2,
    PH_FLAGS = 4'd3,
    PH_LENL  = 4'd4,
    PH_LENH  = 4'd5,
    PH_DATA  = 4'd6,
    PH_CRCL  = 4'd7,
    PH_CRCH  = 4'd8
  } phase_e;

  typedef enum logic {
    MODE_PARSE,
    MODE_DRAIN
  } mode_e;

  phase_e      phase_q, phase_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  sync_first_q, sync_second_q;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] len_q, len_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] fcrc_q, fcrc_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  logic          in_ready, in_fire, out_free;
  logic          restart, hunt_hit;
  logic [7:0]    b;
  logic [15:0]   crc_next, len_full, fcrc_full;
  logic [6:0]    cnt_inc;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // payload store
  fpp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign b         = in_if.rx_byte;
  assign out_free  = !out_valid_q || out_if.ready;
  assign in_ready  = (mode_q == MODE_PARSE) &&
                     (out_free || (phase_q != PH_LENH && phase_q != PH_CRCH));
  assign in_fire   = in_if.valid && in_ready;
  assign crc_next  = crc_byte(crc_q, b);
  assign len_full  = {b, len_q[7:0]};
  assign fcrc_full = {b, fcrc_q[7:0]};
  assign cnt_inc   = {1'b0, cnt_q} + 7'd1;

  // next-state logic: byte parser, result register and payload readout
  always_comb begin
    phase_d     = phase_q;
    mode_d      = mode_q;
    type_d      = type_q;
    flags_d     = flags_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    fcrc_d      = fcrc_q;
    crc_d       = crc_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    restart     = 1'b0;
    hunt_hit    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cnt_inc[AW-1:0];

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    // payload readout: other fields repeat the header already in the register
    if (mode_q == MODE_DRAIN && out_free) begin
      res_d.kind      = KIND_DATA;
      res_d.data_byte = ram_rdata;
      res_d.last      = ({9'd0, cnt_inc} == res_q.payload_length);
      out_valid_d     = 1'b1;
      if (res_d.last) begin
        mode_d = MODE_PARSE;
      end else begin
        ram_re = 1'b1;
        cnt_d  = cnt_inc[5:0];
      end
    end

    if (in_fire) begin
      case (phase_q)
        PH_SYNC2: begin
          if (b == sync_second_q) begin
            phase_d = PH_TYPE;
          end else begin
            restart = 1'b1;
          end
        end
        PH_TYPE: begin
          type_d  = b;
          crc_d   = crc_next;
          phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_d = b;
          crc_d   = crc_next;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          len_d   = {8'h00, b};
          crc_d   = crc_next;
          phase_d = PH_LENH;
        end
        PH_LENH: begin
          len_d = len_full;
          crc_d = crc_next;
          if (len_full > MaxLen) begin
            res_d.kind           = KIND_TOO_LONG;
            res_d.pkt_type       = type_q;
            res_d.frame_flags    = flags_q;
            res_d.payload_length = len_full;
            res_d.data_byte      = 8'h00;
            res_d.received_crc   = 16'h0000;
            res_d.computed_crc   = 16'h0000;
            res_d.last           = 1'b1;
            out_valid_d          = 1'b1;
            restart              = 1'b1;
          end else if (len_full == 16'h0000) begin
            phase_d = PH_CRCL;
          end else begin
            idx_d   = 6'd0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          // index stays below the length, which is at most the buffer depth
          ram_we = 1'b1;
          crc_d  = crc_next;
          idx_d  = idx_q + 6'd1;
          if ({10'd0, idx_d} >= len_q) begin
            phase_d = PH_CRCL;
          end
        end
        PH_CRCL: begin
          fcrc_d  = {8'h00, b};
          phase_d = PH_CRCH;
        end
        PH_CRCH: begin
          res_d.pkt_type       = type_q;
          res_d.frame_flags    = flags_q;
          res_d.payload_length = len_q;
          res_d.data_byte      = 8'h00;
          res_d.received_crc   = fcrc_full;
          res_d.computed_crc   = crc_q;
          out_valid_d          = 1'b1;
          if (fcrc_full == crc_q) begin
            res_d.kind = KIND_HEADER;
            res_d.last = (len_q == 16'h0000);
            if (len_q != 16'h0000) begin
              // fetch payload byte 0 so it is ready after the header
              mode_d    = MODE_DRAIN;
              cnt_d     = 6'd0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
          end else begin
            res_d.kind = KIND_CRC_ERR;
            res_d.last = 1'b1;
          end
          restart = 1'b1;
        end
        default: begin
          // hunting for sync1; unused codes fall back here
          restart  = 1'b1;
          hunt_hit = (b == sync_first_q);
        end
      endcase
    end

    if (restart) begin
      phase_d = PH_SYNC1;
      type_d  = 8'h00;
      flags_d = 8'h00;
      len_d   = 16'h0000;
      idx_d   = 6'd0;
      fcrc_d  = 16'h0000;
      crc_d   = CRC_INIT;
    end
    if (hunt_hit) begin
      phase_d = PH_SYNC2;
    end
  end

  // state, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SYNC1;
      mode_q        <= MODE_PARSE;
      sync_first_q  <= 8'hAA;
      sync_second_q <= 8'h55;
      type_q        <= 8'h00;
      flags_q       <= 8'h00;
      len_q         <= 16'h0000;
      idx_q         <= 6'd0;
      cnt_q         <= 6'd0;
      fcrc_q        <= 16'h0000;
      crc_q         <= CRC_INIT;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      type_q      <= type_d;
      flags_q     <= flags_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      fcrc_q      <= fcrc_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
          REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = res_q.kind;
  assign out_if.pkt_type       = res_q.pkt_type;
  assign out_if.frame_flags    = res_q.frame_flags;
  assign out_if.payload_length = res_q.payload_length;
  assign out_if.data_byte      = res_q.data_byte;
  assign out_if.received_crc   = res_q.received_crc;
  assign out_if.computed_crc   = res_q.computed_crc;
  assign out_if.last           = res_q.last;

endmodule

// File: design/fpp_checker.sv
// Port-level checker for the framed packet parser, bound to the top level.
module fpp_checker
  import fpp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_pkt_type,
  input logic [7:0]  out_flags,
  input logic [15:0] out_length,
  input logic [7:0]  out_data,
  input logic        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data)
                                && $stable(out_last))
    else $error("stalled result changed");

  // while a frame is still being read out no byte is taken
  a_drain_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken during payload readout");

  // a non-final result is followed at once by a payload byte
  a_next_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid && out_kind == KIND_DATA)
    else $error("payload byte missing after non-final result");

  // payload results repeat the frame header fields
  a_hdr_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=>
      $stable(out_pkt_type) && $stable(out_flags) && $stable(out_length))
    else $error("header fields changed within a frame");

endmodule

bind framed_packet_parser_crc16 fpp_checker u_fpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_kind     (out_if.kind),
  .out_pkt_type (out_if.pkt_type),
  .out_flags    (out_if.frame_flags),
  .out_length   (out_if.payload_length),
  .out_data     (out_if.data_byte),
  .out_last     (out_if.last)
);

// File: tb/tb.sv
// Self-checking testbench for the framed packet parser: frame stimulus, byte-level predictor.
module tb
  import fpp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_BYTES = 6;

  // Parser phases of the predictor
  typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC2, ST_PKT_TYPE, ST_FLAGS, ST_LEN_LO, ST_LEN_HI,
    ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
  } parse_st_e;

  // One frame of stimulus; typed marks a row whose result is written in below
  typedef struct {
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  pkt_type;
    logic [7:0]  flags;
    logic [15:0] len;
    logic [7:0]  fill;
    bit          bad_crc;
    bit          typed;
    result_t     res;
  } frame_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [7:0]          cfg_data_i;

  fpp_in_if  in_ch ();
  fpp_out_if out_ch ();

  framed_packet_parser_crc16 #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Directed frames: wrong second sync, oversize extreme, empty frame, bad CRC
  frame_row_t dir_rows [4] = '{
    '{s1: 8'hAA, s2: 8'hAA, pkt_type: 8'h00, flags: 8'h00, len: 16'h0000, fill: 8'h00,
      bad_crc: 1'b0, typed: 1'b0, res: '0},
    '{s1: 8'hAA, s2: 8'h55, pkt_type: 8'hFF, flags: 8'hFF, len: 16'hFFFF, fill: 8'h00,
      bad_crc: 1'b0, typed: 1'b1,
      res: '{kind: KIND_TOO_LONG, pkt_type: 8'hFF, frame_flags: 8'hFF,
             payload_length: 16'hFFFF, data_byte: 8'h00, received_crc: 16'h0000,
             computed_crc: 16'h0000, last: 1'b1}},
    '{s1: 8'hAA, s2: 8'h55, pkt_type: 8'h00, flags: 8'h00, len: 16'h0000, fill: 8'h00,
      bad_crc: 1'b0, typed: 1'b0, res: '0},
    '{s1: 8'hAA, s2: 8'h55, pkt_type: 8'h5A, flags: 8'hA5, len: 16'h0001, fill: 8'hFF,
      bad_crc: 1'b1, typed: 1'b0, res: '0}
  };

  // Predictor state and register copies
  parse_st_e   pst;
  logic [7:0]  hd_type;
  logic [7:0]  hd_flags;
  logic [15:0] hd_len;
  logic [5:0]  pay_idx;
  logic [7:0]  pay_mem [MAX_PAYLOAD];
  logic [15:0] rx_crc;
  logic [15:0] run_crc;
  logic [7:0]  cfg_first;
  logic [7:0]  cfg_second;

  result_t     step_res [$];
  result_t     expected_q [$];
  int unsigned err_cnt;
  int unsigned bytes_sent;
  int unsigned stall_cycles;

  // Sender side of a typed row, moved along with the item it belongs to
  bit          tx_typed;
  result_t     tx_typed_res;

  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;

  // CRC-16/CCITT-FALSE, one message bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame();
    pst     = ST_HUNT;
    hd_type = '0;
    hd_flags = '0;
    hd_len  = '0;
    pay_idx = '0;
    rx_crc  = '0;
    run_crc = CRC_INIT;
  endfunction

  function automatic void add_result(input kind_e k, input logic [7:0] d,
                                     input logic [15:0] rc, input logic [15:0] cc,
                                     input logic l);
    result_t r;
    r.kind           = k;
    r.pkt_type       = hd_type;
    r.frame_flags    = hd_flags;
    r.payload_length = hd_len;
    r.data_byte      = d;
    r.received_crc   = rc;
    r.computed_crc   = cc;
    r.last           = l;
    step_res.push_back(r);
  endfunction

  // Advance the predictor by one received byte; results go to step_res
  function automatic void parse_byte(input logic [7:0] b);
    case (pst)
      ST_SYNC2: begin
        if (b == cfg_second) pst = ST_PKT_TYPE;
        else clear_frame();
      end
      ST_PKT_TYPE: begin
        hd_type = b;
        run_crc = crc16_update(run_crc, b);
        pst = ST_FLAGS;
      end
      ST_FLAGS: begin
        hd_flags = b;
        run_crc = crc16_update(run_crc, b);
        pst = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        hd_len = {8'h00, b};
        run_crc = crc16_update(run_crc, b);
        pst = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        hd_len[15:8] = b;
        run_crc = crc16_update(run_crc, b);
        if (hd_len > MAX_PAYLOAD) begin
          add_result(KIND_TOO_LONG, 8'h00, 16'h0000, 16'h0000, 1'b1);
          clear_frame();
        end else if (hd_len == 0) begin
          pst = ST_CRC_LO;
        end else begin
          pay_idx = '0;
          pst = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (pay_idx < MAX_PAYLOAD) pay_mem[pay_idx] = b;
        run_crc = crc16_update(run_crc, b);
        pay_idx = pay_idx + 6'd1;
        if (16'(pay_idx) >= hd_len) pst = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        rx_crc = {8'h00, b};
        pst = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        rx_crc[15:8] = b;
        if (rx_crc == run_crc) begin
          add_result(KIND_HEADER, 8'h00, rx_crc, run_crc, hd_len == 0);
          for (int i = 0; i < int'(hd_len); i++) begin
            add_result(KIND_DATA, pay_mem[i], rx_crc, run_crc, i + 1 == int'(hd_len));
          end
        end else begin
          add_result(KIND_CRC_ERR, 8'h00, rx_crc, run_crc, 1'b1);
        end
        clear_frame();
      end
      default: begin
        if (pst != ST_HUNT) clear_frame();
        if (b == cfg_first) pst = ST_SYNC2;
      end
    endcase
  endfunction

  // Result checker and input-side prediction
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind           = out_ch.kind;
        got.pkt_type       = out_ch.pkt_type;
        got.frame_flags    = out_ch.frame_flags;
        got.payload_length = out_ch.payload_length;
        got.data_byte      = out_ch.data_byte;
        got.received_crc   = out_ch.received_crc;
        got.computed_crc   = out_ch.computed_crc;
        got.last           = out_ch.last;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (want.kind !== got.kind || want.pkt_type !== got.pkt_type ||
              want.frame_flags !== got.frame_flags ||
              want.payload_length !== got.payload_length ||
              want.data_byte !== got.data_byte || want.received_crc !== got.received_crc ||
              want.computed_crc !== got.computed_crc || want.last !== got.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_res.delete();
        parse_byte(in_ch.rx_byte);
        if (tx_typed) begin
          expected_q.push_back(tx_typed_res);
        end else begin
          foreach (step_res[i]) expected_q.push_back(step_res[i]);
        end
      end
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Result sink: random stalls per item, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      // a hold-off request ends the wait at once
      do @(posedge clk_i); while (!out_ch.valid && !hold_req);
    end
  end

  // Offer one byte after a random gap and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t res);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    tx_typed      <= typed;
    tx_typed_res  <= res;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Send a frame; stops early where the parser gives up on it
  task automatic send_frame(input frame_row_t row, input bit rand_data);
    logic [15:0] crc;
    logic [7:0]  d;
    send_byte(row.s1, 1'b0, '0);
    send_byte(row.s2, 1'b0, '0);
    if (row.s2 != cfg_second) return;
    crc = CRC_INIT;
    send_byte(row.pkt_type, 1'b0, '0);
    crc = crc16_update(crc, row.pkt_type);
    send_byte(row.flags, 1'b0, '0);
    crc = crc16_update(crc, row.flags);
    send_byte(row.len[7:0], 1'b0, '0);
    crc = crc16_update(crc, row.len[7:0]);
    send_byte(row.len[15:8], row.typed, row.res);
    crc = crc16_update(crc, row.len[15:8]);
    if (row.len > MAX_PAYLOAD) return;
    for (int i = 0; i < int'(row.len); i++) begin
      d = rand_data ? 8'($urandom_range(0, 255)) : row.fill;
      send_byte(d, 1'b0, '0);
      crc = crc16_update(crc, d);
    end
    if (row.bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[7:0], 1'b0, '0);
    send_byte(crc[15:8], 1'b0, '0);
  endtask

  // Mostly well-formed frames, some broken ones and stray bytes
  task automatic run_random(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned sz;
    frame_row_t  row;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      sz   = $urandom_range(0, 9);
      row.s1       = cfg_first;
      row.s2       = cfg_second;
      row.pkt_type = 8'($urandom_range(0, 255));
      row.flags    = 8'($urandom_range(0, 255));
      row.fill     = 8'h00;
      row.bad_crc  = 1'b0;
      row.typed    = 1'b0;
      row.res      = '0;
      // short payloads mostly, the full size now and then
      if (sz < 7) row.len = 16'($urandom_range(0, 6));
      else if (sz == 7) row.len = 16'(MAX_PAYLOAD);
      else if (sz == 8) row.len = 16'($urandom_range(MAX_PAYLOAD - 1, MAX_PAYLOAD));
      else row.len = 16'($urandom_range(0, MAX_PAYLOAD));
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        if (pick < 16) begin
          row.s2 = cfg_second ^ 8'($urandom_range(1, 255));
        end else if (pick < 24) begin
          row.len = ($urandom_range(0, 2) == 0) ? 16'(MAX_PAYLOAD + 1)
                                                : 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        end else if (pick < 34) begin
          row.bad_crc = 1'b1;
        end
        send_frame(row, 1'b1);
      end
    end
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    // let the monitor record the results of the last byte first
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both sync registers while idle
  task automatic set_syncs(input logic [7:0] first, input logic [7:0] second);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SYNC_FIRST;
    cfg_data_i <= first;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SYNC_SECOND;
    cfg_data_i <= second;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_first  = first;
    cfg_second = second;
  endtask

  initial begin : stimulus
    logic [7:0] same;
    frame_row_t hold_row;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_SYNC_FIRST;
    cfg_data_i    <= 8'h00;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    tx_typed      <= 1'b0;
    tx_typed_res  <= '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_req      = 1'b0;
    err_cnt       = 0;
    bytes_sent    = 0;
    stall_cycles  = 0;
    cfg_first     = 8'hAA;
    cfg_second    = 8'h55;
    foreach (pay_mem[i]) pay_mem[i] = 8'h00;
    clear_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames with the reset sync values
    foreach (dir_rows[i]) send_frame(dir_rows[i], 1'b0);
    drain_results();

    // random frames, reset sync values
    run_random(RAND_BYTES);
    drain_results();

    // extremes, no idling, long result hold-off so the input backs up
    set_syncs(8'h00, 8'hFF);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    // oversize frames back to back: one result waits, a later length byte stalls
    hold_row       = dir_rows[1];
    hold_row.s1    = cfg_first;
    hold_row.s2    = cfg_second;
    hold_row.typed = 1'b0;
    repeat (3) send_frame(hold_row, 1'b0);
    run_random(RAND_BYTES);
    drain_results();

    set_syncs(8'hFF, 8'h00);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(RAND_BYTES);
    drain_results();

    set_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    run_random(RAND_BYTES);
    drain_results();

    // both sync bytes equal
    same = 8'($urandom_range(0, 255));
    set_syncs(same, same);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    run_random(RAND_BYTES);
    drain_results();

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
